FILE: rtl/rar_pkg.sv
// Package: shared types and constants for the rational arithmetic reducer.
`timescale 1ns / 1ps
package rar_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RAW_W = 64;
  localparam int CNT_W = 6;
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [RAW_W-1:0] num;
    logic [RAW_W-1:0] den;
    logic             do_red;
  } job_t;
endpackage

FILE: rtl/rar_front.sv
// Front end: accepts transactions, cross multiplies and classifies them.
`timescale 1ns / 1ps
module rar_front #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  input  logic                            q_full,
  output logic                            q_push,
  output rar_pkg::job_t                   q_data
);
  localparam int PW = 2 * OPERAND_WIDTH;

  logic signed [PW-1:0] p0_r, p1_r, pd_r, p0_nxt, p1_nxt, pd_nxt;
  logic [1:0] op_r;
  logic       vld_r;
  logic       take;
  logic signed [OPERAND_WIDTH-1:0] m0b, mdb;
  logic [rar_pkg::RAW_W-1:0] e0, e1, num, den;

  assign q_push = vld_r && !q_full;
  assign full   = vld_r && q_full;
  assign take   = push && !full;

  // divide swaps b's parts; multiply pairs numerators
  always_comb begin
    m0b = in_b_den;
    mdb = in_b_den;
    case (rar_pkg::opcode_t'(in_opcode))
      rar_pkg::OP_MUL: m0b = in_b_num;
      rar_pkg::OP_DIV: mdb = in_b_num;
      default: ;
    endcase
    p0_nxt = in_a_num * m0b;
    p1_nxt = in_b_num * in_a_den;
    pd_nxt = in_a_den * mdb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (q_push) begin
      vld_r <= 1'b0;
    end
    if (take) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      pd_r <= pd_nxt;
      op_r <= in_opcode;
    end
  end

  always_comb begin
    e0  = rar_pkg::RAW_W'(p0_r);
    e1  = rar_pkg::RAW_W'(p1_r);
    den = rar_pkg::RAW_W'(pd_r);
    case (rar_pkg::opcode_t'(op_r))
      rar_pkg::OP_ADD: num = e0 + e1;
      rar_pkg::OP_SUB: num = e0 - e1;
      default:         num = e0;
    endcase
    q_data.num    = num;
    q_data.den    = den;
    q_data.do_red = !den[rar_pkg::RAW_W-1] && (den[rar_pkg::RAW_W-1:1] != '0);
  end
endmodule

FILE: rtl/rar_queue.sv
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module rar_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  rar_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output rar_pkg::job_t rdata
);
  rar_pkg::job_t mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r[1];
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem[wp_r] <= wdata;
  end
endmodule

FILE: rtl/rar_back.sv
// Back end: binary gcd, then two restoring divisions when the factor exceeds one, into an output register.
`timescale 1ns / 1ps
module rar_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  rar_pkg::job_t                      q_data,
  output logic                               q_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rar_pkg::NUM_OUT_W-1:0] out_res_num,
  output logic signed [rar_pkg::DEN_OUT_W-1:0] out_res_den,
  output logic                               out_was_reduced
);
  localparam int W = rar_pkg::RAW_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GCD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  logic [W-1:0] num_r, den_r, u_r, v_r, g_r, ra_r, rb_r;
  logic         neg_r, red_r;
  logic [rar_pkg::CNT_W-1:0] k_r, cnt_r;
  logic         out_vld_r;
  logic [W-1:0] mag, diff_uv, diff_vu, sa, sb, gsh;
  logic         load_out;

  assign mag     = q_data.num[W-1] ? (W'(0) - q_data.num) : q_data.num;
  assign diff_uv = u_r - v_r;
  assign diff_vu = v_r - u_r;
  assign gsh     = v_r << k_r;
  assign sa      = {ra_r[W-2:0], num_r[W-1]};
  assign sb      = {rb_r[W-2:0], den_r[W-1]};

  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign load_out = (st_r == ST_DONE) && (!out_vld_r || pop);
  assign empty    = !out_vld_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (!q_empty) st_nxt = q_data.do_red ? ST_GCD : ST_DONE;
      ST_GCD:  if (u_r == '0) st_nxt = (gsh == W'(1)) ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_r == '1) st_nxt = ST_DONE;
      ST_DONE: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) out_vld_r <= 1'b1;
      else if (pop) out_vld_r <= 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        num_r <= q_data.num;
        den_r <= q_data.den;
        neg_r <= q_data.num[W-1];
        red_r <= 1'b0;
        u_r   <= mag;
        v_r   <= q_data.den;
        k_r   <= '0;
      end
      ST_GCD: begin
        if (u_r == '0) begin
          // prepare divisions: mag / g and den / g, one quotient bit a cycle;
          // with g of one the raw numerator is kept as it is
          g_r   <= gsh;
          if (gsh != W'(1)) num_r <= neg_r ? (W'(0) - num_r) : num_r;
          ra_r  <= '0;
          rb_r  <= '0;
          cnt_r <= '0;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= diff_uv >> 1;
        end else begin
          v_r <= diff_vu >> 1;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (sa >= g_r) begin
          ra_r  <= sa - g_r;
          num_r <= {num_r[W-2:0], 1'b1};
        end else begin
          ra_r  <= sa;
          num_r <= {num_r[W-2:0], 1'b0};
        end
        if (sb >= g_r) begin
          rb_r  <= sb - g_r;
          den_r <= {den_r[W-2:0], 1'b1};
        end else begin
          rb_r  <= sb;
          den_r <= {den_r[W-2:0], 1'b0};
        end
        if (cnt_r == '1) begin
          red_r <= 1'b1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_res_num     <= red_r ? rar_pkg::NUM_OUT_W'(neg_r ? (W'(0) - num_r) : num_r)
                                   : rar_pkg::NUM_OUT_W'(num_r);
          out_res_den     <= rar_pkg::DEN_OUT_W'(den_r);
          out_was_reduced <= red_r;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/rational_arith_reduce.sv
// Top level of the rational arithmetic reducer.
// Each transaction carries an opcode (add, subtract, multiply, divide) and two
// signed fractions; the block cross multiplies into a raw numerator and
// denominator (formed modulo 2^64), and when the raw denominator is at least 2
// divides both by gcd(|num|, den), flagging was_reduced if the factor exceeded
// one. Signs are never normalized. A front end registers the three products
// and forms the sum or difference into a two-entry queue; the back end takes
// one job at a time. A job that needs reduction runs the binary gcd loop (one
// shift or subtract-and-shift per cycle) and, if the factor exceeds one, the
// two restoring dividers that run side by side; the gcd loop and the dividers
// set the rate. Results wait in an output register while the next transactions
// keep entering the front end until the queue and the front end register fill.
`timescale 1ns / 1ps
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_den,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rar_pkg::NUM_OUT_W-1:0] out_res_num,
  output logic signed [rar_pkg::DEN_OUT_W-1:0] out_res_den,
  output logic                               out_was_reduced
);
  rar_pkg::job_t wjob, rjob;
  logic q_wr, q_full, q_rd, q_empty;

  rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .push, .full,
    .in_opcode, .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .q_full(q_full), .q_push(q_wr), .q_data(wjob)
  );

  rar_queue u_queue (
    .clk, .rst_n, .wr(q_wr), .wdata(wjob), .full(q_full),
    .rd(q_rd), .empty(q_empty), .rdata(rjob)
  );

  rar_back u_back (
    .clk, .rst_n, .q_empty(q_empty), .q_data(rjob), .q_pop(q_rd),
    .empty, .pop, .out_res_num, .out_res_den, .out_was_reduced
  );
endmodule

FILE: rtl/rar_checker.sv
// Port-level checker for the rational arithmetic reducer, with its bind.
`timescale 1ns / 1ps
module rar_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               empty,
  input logic                               pop,
  input logic signed [rar_pkg::NUM_OUT_W-1:0] out_res_num,
  input logic signed [rar_pkg::DEN_OUT_W-1:0] out_res_den,
  input logic                               out_was_reduced
);
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present right after reset");

  a_zero_reduces_to_one: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_was_reduced && out_res_num == '0) |-> out_res_den == 1)
    else $error("reduced zero numerator without unit denominator");

  a_reduced_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_was_reduced) |-> out_res_den != '0)
    else $error("reduced result with zero denominator");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_res_num) && $stable(out_res_den)
                          && $stable(out_was_reduced)))
    else $error("waiting result changed");
endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);

FILE: bench/tb_rational_arith_reduce.sv
// Testbench for rational_arith_reduce: random and directed fraction arithmetic, checked per field.
`timescale 1ns / 1ps
module tb_rational_arith_reduce;

  localparam int OW = 16;
  localparam int N_RANDOM = 1900;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    rar_pkg::opcode_t op;
    logic [OW-1:0]    a_num, a_den, b_num, b_den;
  } frac_op_t;

  typedef struct {
    logic [rar_pkg::NUM_OUT_W-1:0] num;
    logic [rar_pkg::DEN_OUT_W-1:0] den;
    logic                          red;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] in_opcode = '0;
  logic signed [OW-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic full, empty, out_was_reduced;
  logic signed [rar_pkg::NUM_OUT_W-1:0] out_res_num;
  logic signed [rar_pkg::DEN_OUT_W-1:0] out_res_den;
  logic full_q;

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  int        errors = 0;
  int        cycles = 0;
  bit        stim_done = 0;

  rational_arith_reduce #(.OPERAND_WIDTH(OW)) i_dut (
    .clk, .rst_n, .push, .full, .in_opcode, .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .empty, .pop, .out_res_num, .out_res_den, .out_was_reduced
  );

  always #5 clk = ~clk;

  // Cross multiply modulo 2^64, then reduce by gcd when den >= 2 (signed).
  function automatic frac_res_t reduce_frac(frac_op_t t);
    logic [63:0] an, ad, bn, bd, num, den, mag, x, y, r;
    logic        neg;
    frac_res_t   res;
    an = 64'(signed'(t.a_num));
    ad = 64'(signed'(t.a_den));
    bn = 64'(signed'(t.b_num));
    bd = 64'(signed'(t.b_den));
    res.red = 1'b0;
    case (t.op)
      rar_pkg::OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      rar_pkg::OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      rar_pkg::OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (!den[63] && den >= 64'd2) begin
      neg = num[63];
      mag = neg ? -num : num;
      x = mag;
      y = den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      if (x > 1) begin
        mag = mag / x;
        den = den / x;
        num = neg ? -mag : mag;
        res.red = 1'b1;
      end
    end
    res.num = num[rar_pkg::NUM_OUT_W-1:0];
    res.den = den[rar_pkg::DEN_OUT_W-1:0];
    return res;
  endfunction

  function automatic logic [OW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 6)) - 3);
      3, 4: return 16'($urandom_range(1, 60));
      5: return -16'($urandom_range(1, 60));
      6: return 16'($urandom_range(1, 12) * $urandom_range(1, 12) * 6);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_op(rar_pkg::opcode_t op, logic [OW-1:0] an, ad, bn, bd);
    frac_op_t t;
    t.op = op; t.a_num = an; t.a_den = ad; t.b_num = bn; t.b_den = bd;
    pending_ops.push_back(t);
  endtask

  // Stimulus: directed corners then random mix.
  initial begin
    frac_op_t t;
    for (int o = 0; o < 4; o++) begin
      add_op(rar_pkg::opcode_t'(o), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(rar_pkg::opcode_t'(o), 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
      add_op(rar_pkg::opcode_t'(o), 16'd0, 16'd4, 16'd0, 16'd6);   // zero numerator -> 0/1, except divide (0/0)
      add_op(rar_pkg::opcode_t'(o), 16'd3, 16'd0, 16'd5, 16'd7);   // zero denominator
      add_op(rar_pkg::opcode_t'(o), 16'd2, -16'd3, 16'd5, 16'd7);  // negative denominator
    end
    add_op(rar_pkg::OP_MUL, 16'd3, 16'd1, 16'd5, 16'd1);           // denominator one
    add_op(rar_pkg::OP_ADD, 16'd1, 16'd3, 16'd1, 16'd5);           // gcd one
    add_op(rar_pkg::OP_ADD, 16'd1, 16'd6, 16'd1, 16'd3);           // reduces to 1/2
    add_op(rar_pkg::OP_DIV, -16'd4, 16'd9, 16'd2, 16'd3);
    add_op(rar_pkg::OP_SUB, 16'hffff, 16'h5555, 16'haaaa, 16'h0001);
    add_op(rar_pkg::OP_SUB, -16'd1, 16'd3, 16'd1, 16'd5);          // negative, gcd one
    for (int i = 0; i < N_RANDOM; i++) begin
      t.op = rar_pkg::opcode_t'($urandom_range(0, 3));
      t.a_num = rand_operand(); t.a_den = rand_operand();
      t.b_num = rand_operand(); t.b_den = rand_operand();
      pending_ops.push_back(t);
    end
  end

  // Driver: bursts of pushes with random gaps, changes at falling edge.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (push && !full_q) begin
        void'(pending_ops.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pending_ops.size() > 0 && !(push && !full_q && pending_ops.size() == 0)) begin
        push <= 1'b1;
        in_opcode <= pending_ops[0].op;
        in_a_num <= pending_ops[0].a_num;
        in_a_den <= pending_ops[0].a_den;
        in_b_num <= pending_ops[0].b_num;
        in_b_den <= pending_ops[0].b_den;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
        end
      end else begin
        push <= 1'b0;
        if (pending_ops.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // Acceptance sampled at rising edge; the predictor runs on the accepted transaction.
  always @(posedge clk) begin
    full_q <= full;
    if (rst_n && push && !full) begin
      expected_fracs.push_back(reduce_frac(pending_ops[0]));
    end
  end

  // Receiver stall pattern: free-flowing, lightly stalled and heavily stalled stretches in turn.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 3000;
    if (stall_phase < 1000) pop <= 1'b1;
    else if (stall_phase < 2000) pop <= ($urandom_range(0, 3) != 0);
    else pop <= ($urandom_range(0, 15) == 0);
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && pop && !empty) begin
      if (expected_fracs.size() == 0) begin
        $error("unexpected result num=%0h den=%0h", out_res_num, out_res_den);
        errors++;
      end else begin
        e = expected_fracs.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num expected %0h actual %0h", e.num, out_res_num); errors++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den expected %0h actual %0h", e.den, out_res_den); errors++;
        end
        if (out_was_reduced !== e.red) begin
          $error("was_reduced expected %0b actual %0b", e.red, out_was_reduced); errors++;
        end
      end
    end
  end

  // Reset, then wait for drain and latency; cycle counter guards against hangs.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_done && expected_fracs.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_fracs.size() == 0) $display("** rational_arith_reduce: PASSED **");
    else $display("** rational_arith_reduce: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** rational_arith_reduce: FAILED **");
      $finish;
    end
  end
endmodule

FILE: rational_arith_reduce.f
rtl/rar_pkg.sv
rtl/rar_front.sv
rtl/rar_queue.sv
rtl/rar_back.sv
rtl/rational_arith_reduce.sv
rtl/rar_checker.sv
bench/tb_rational_arith_reduce.sv
